@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ABT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed in same cycle");
`define ABT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed in next cycle");
`else
`define ABT_ASSERT_IMP(lbl, ante, cons)
`define ABT_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ rtl/abt_pkg.sv @@
// ----------------------------------------------------------------------------
// abt_pkg
// Types, codes and helper functions shared by the ban tracker modules.
// ----------------------------------------------------------------------------
package abt_pkg;

    localparam int IN_W  = 184;
    localparam int OUT_W = 104;

    localparam logic [2:0] REG_ABUSE_THR = 3'd0;
    localparam logic [2:0] REG_BASE_BAN  = 3'd1;
    localparam logic [2:0] REG_GROWTH    = 3'd2;
    localparam logic [2:0] REG_BL_EN     = 3'd3;
    localparam logic [2:0] REG_BL_THR    = 3'd4;
    localparam logic [2:0] REG_STALE     = 3'd5;

    typedef enum logic [2:0] {
        ACT_BLOCKED = 3'd0,
        ACT_WHITE   = 3'd1,
        ACT_WATCH   = 3'd2,
        ACT_BANNED  = 3'd3,
        ACT_BLACK   = 3'd4,
        ACT_FULL    = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        KIND_NORMAL  = 2'd0,
        KIND_BLOCKED = 2'd1,
        KIND_WHITE   = 2'd2
    } kind_t;

    typedef struct packed {
        logic [31:0] abuse_thr;
        logic [31:0] base_ban;
        logic [4:0]  growth;
        logic        bl_en;
        logic [31:0] bl_thr;
        logic [31:0] stale;
    } cfg_t;

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        v6;
    } addr_t;

    typedef struct packed {
        addr_t       addr;
        logic [15:0] danger;
        logic [31:0] now;
        kind_t       kind;
    } req_t;

    typedef struct packed {
        addr_t       addr;
        logic [15:0] hits;
        logic [31:0] danger;
        logic [31:0] first;
    } pent_t;

    typedef struct packed {
        addr_t       addr;
        logic [15:0] count;
        logic [31:0] danger;
        logic [31:0] last;
    } oent_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] sat_inc16(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

endpackage

@@ rtl/attacker_ban_tracker_top.sv @@
// ----------------------------------------------------------------------------
// attacker_ban_tracker_top
// Attack reports go through a two-entry queue to an engine that handles one
// request at a time, so the time per request is set by the table scans. The
// engine takes a request, scans the pending table through a single memory
// read port and then updates it. A request that reaches the abuse threshold
// also scans the offender table and updates it. A growing ban then performs
// one multiplication per repeat offence, at most 32 before the ban time
// saturates, and finishes. The result is then loaded into the output
// register. A result that is still waiting in the output register holds the
// engine until it is taken. The tables need no clearing after reset.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module attacker_ban_tracker_top
#(
    parameter int PENDING_DEPTH  = 64,
    parameter int OFFENDER_DEPTH = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // addr_high, addr_low, addr_is_v6, danger, now_seconds, already_blocked,
    // whitelisted, zero pad
    input  logic [abt_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // action, ban_seconds, pending_hits, offence_count, offender_danger, zero pad
    output logic [abt_pkg::OUT_W-1:0] m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [2:0]                cfg_addr,
    input  logic [31:0]               cfg_wdata
);

    abt_pkg::cfg_t cfg_reg;
    abt_pkg::req_t req;
    logic          req_valid;
    logic          req_ready;
    logic [2:0]    out_act;
    logic          early_act;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.abuse_thr <= 32'd30;
            cfg_reg.base_ban  <= 32'd120;
            cfg_reg.growth    <= 5'd1;
            cfg_reg.bl_en     <= 1'b0;
            cfg_reg.bl_thr    <= 32'd120;
            cfg_reg.stale     <= 32'd1800;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                abt_pkg::REG_ABUSE_THR: cfg_reg.abuse_thr <= cfg_wdata;
                abt_pkg::REG_BASE_BAN:  cfg_reg.base_ban  <= cfg_wdata;
                abt_pkg::REG_GROWTH:    cfg_reg.growth    <= cfg_wdata[4:0];
                abt_pkg::REG_BL_EN:     cfg_reg.bl_en     <= cfg_wdata[0];
                abt_pkg::REG_BL_THR:    cfg_reg.bl_thr    <= cfg_wdata;
                abt_pkg::REG_STALE:     cfg_reg.stale     <= cfg_wdata;
                default:                ;
            endcase
        end
    end

    abt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req)
    );

    abt_engine #(
        .PENDING_DEPTH  (PENDING_DEPTH),
        .OFFENDER_DEPTH (OFFENDER_DEPTH)
    ) u_engine
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    assign out_act   = m_tdata[2:0];
    // Blocked, whitelisted and table-full results carry zeros in every other field.
    assign early_act = out_act inside {abt_pkg::ACT_BLOCKED, abt_pkg::ACT_WHITE,
                                       abt_pkg::ACT_FULL};

    `ABT_ASSERT_IMP(a_action_range, m_tvalid, out_act <= abt_pkg::ACT_FULL)
    `ABT_ASSERT_IMP(a_early_zero, m_tvalid && early_act, m_tdata[98:3] == '0)
    `ABT_ASSERT_IMP(a_black_forever, m_tvalid && out_act == abt_pkg::ACT_BLACK, m_tdata[34:3] == '0)
    `ABT_ASSERT_NEXT(a_engine_busy, req_valid && req_ready, !req_ready)

endmodule

@@ rtl/abt_front.sv @@
// ----------------------------------------------------------------------------
// abt_front
// Accepts report requests, classifies them and queues them for the engine.
// ----------------------------------------------------------------------------
module abt_front
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // addr_high, addr_low, addr_is_v6, danger, now_seconds, already_blocked,
    // whitelisted, zero pad
    input  logic [abt_pkg::IN_W-1:0]  s_tdata,
    output logic                      req_valid,
    input  logic                      req_ready,
    output abt_pkg::req_t             req
);

    abt_pkg::req_t q_reg [2];
    logic          wptr_reg;
    logic          rptr_reg;
    logic [1:0]    cnt_reg;
    abt_pkg::req_t in_req;
    logic          push;
    logic          pop;

    always_comb
    begin
        in_req.addr.hi = s_tdata[63:0];
        in_req.addr.lo = s_tdata[127:64];
        in_req.addr.v6 = s_tdata[128];
        in_req.danger  = s_tdata[144:129];
        in_req.now     = s_tdata[176:145];
        // Blocked takes precedence over whitelisted.
        if (s_tdata[177])
            in_req.kind = abt_pkg::KIND_BLOCKED;
        else if (s_tdata[178])
            in_req.kind = abt_pkg::KIND_WHITE;
        else
            in_req.kind = abt_pkg::KIND_NORMAL;
    end

    assign s_tready  = (cnt_reg != 2'd2);
    assign req_valid = (cnt_reg != 2'd0);
    assign req       = q_reg[rptr_reg];
    assign push      = s_tvalid && s_tready;
    assign pop       = req_valid && req_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wptr_reg <= ~wptr_reg;
            if (pop)
                rptr_reg <= ~rptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_reg[wptr_reg] <= in_req;
    end

endmodule

@@ rtl/abt_engine.sv @@
// ----------------------------------------------------------------------------
// abt_engine
// Walks the pending and offender tables for one request and forms the result.
// ----------------------------------------------------------------------------
module abt_engine
#(
    parameter int PENDING_DEPTH  = 64,
    parameter int OFFENDER_DEPTH = 256
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  abt_pkg::cfg_t             cfg,
    input  logic                      req_valid,
    output logic                      req_ready,
    input  abt_pkg::req_t             req,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [abt_pkg::OUT_W-1:0] m_tdata
);

    localparam int PIW = $clog2(PENDING_DEPTH > 1 ? PENDING_DEPTH : 2);
    localparam int PCW = $clog2(PENDING_DEPTH + 1);
    localparam int OIW = $clog2(OFFENDER_DEPTH > 1 ? OFFENDER_DEPTH : 2);
    localparam int OCW = $clog2(OFFENDER_DEPTH + 1);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PSCAN = 7'b0000010,
        ST_PUPD  = 7'b0000100,
        ST_OSCAN = 7'b0001000,
        ST_OUPD  = 7'b0010000,
        ST_GROW  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    abt_pkg::pent_t pmem [PENDING_DEPTH];
    abt_pkg::oent_t omem [OFFENDER_DEPTH];
    abt_pkg::pent_t pq_reg;
    abt_pkg::oent_t oq_reg;

    state_t                    state_reg, state_next;
    abt_pkg::req_t             req_reg, req_next;
    logic [PENDING_DEPTH-1:0]  pvalid_reg, pvalid_next;
    logic [OFFENDER_DEPTH-1:0] ovalid_reg, ovalid_next;
    logic [PCW-1:0]            pcnt_reg, pcnt_next;
    logic [OCW-1:0]            ocnt_reg, ocnt_next;
    logic                      rv_reg, rv_next;
    logic [PIW-1:0]            pridx_reg, pridx_next;
    logic [OIW-1:0]            oridx_reg, oridx_next;
    logic                      hit_reg, hit_next;
    logic [PIW-1:0]            hit_idx_reg, hit_idx_next;
    abt_pkg::pent_t            pent_reg, pent_next;
    logic                      free_reg, free_next;
    logic [PIW-1:0]            free_idx_reg, free_idx_next;
    logic                      ohit_reg, ohit_next;
    logic [OIW-1:0]            ohit_idx_reg, ohit_idx_next;
    abt_pkg::oent_t            oent_reg, oent_next;
    logic                      ofree_reg, ofree_next;
    logic [OIW-1:0]            ofree_idx_reg, ofree_idx_next;
    logic [OIW-1:0]            old_idx_reg, old_idx_next;
    logic [31:0]               old_age_reg, old_age_next;
    abt_pkg::action_t          act_reg, act_next;
    logic [31:0]               ban_reg, ban_next;
    logic [15:0]               hits_reg, hits_next;
    logic [15:0]               cnt_reg, cnt_next;
    logic [31:0]               odng_reg, odng_next;
    logic [31:0]               pdng_reg, pdng_next;
    logic [15:0]               k_reg, k_next;
    logic                      out_valid_reg, out_valid_next;
    logic [abt_pkg::OUT_W-1:0] out_data_reg, out_data_next;

    logic                      pwe;
    logic [PIW-1:0]            pwa;
    abt_pkg::pent_t            pwd;
    logic                      owe;
    logic [OIW-1:0]            owa;
    abt_pkg::oent_t            owd;
    logic [PIW-1:0]            pra;
    logic [OIW-1:0]            ora;

    always_ff @(posedge clk)
    begin
        if (pwe)
            pmem[pwa] <= pwd;
        pq_reg <= pmem[pra];
        if (owe)
            omem[owa] <= owd;
        oq_reg <= omem[ora];
    end

    assign pra       = pcnt_reg[PIW-1:0];
    assign ora       = ocnt_reg[OIW-1:0];
    assign req_ready = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    always_comb
    begin
        logic [31:0]    age_p;
        logic [31:0]    age_o;
        logic           stale;
        logic           pv;
        logic [PIW-1:0] pslot;
        logic [OIW-1:0] oslot;
        logic [15:0]    nh;
        logic [31:0]    nd;
        logic [15:0]    nc;
        logic [31:0]    nod;
        logic [36:0]    prod;

        state_next     = state_reg;
        req_next       = req_reg;
        pvalid_next    = pvalid_reg;
        ovalid_next    = ovalid_reg;
        pcnt_next      = pcnt_reg;
        ocnt_next      = ocnt_reg;
        rv_next        = 1'b0;
        pridx_next     = pridx_reg;
        oridx_next     = oridx_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        pent_next      = pent_reg;
        free_next      = free_reg;
        free_idx_next  = free_idx_reg;
        ohit_next      = ohit_reg;
        ohit_idx_next  = ohit_idx_reg;
        oent_next      = oent_reg;
        ofree_next     = ofree_reg;
        ofree_idx_next = ofree_idx_reg;
        old_idx_next   = old_idx_reg;
        old_age_next   = old_age_reg;
        act_next       = act_reg;
        ban_next       = ban_reg;
        hits_next      = hits_reg;
        cnt_next       = cnt_reg;
        odng_next      = odng_reg;
        pdng_next      = pdng_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        pwe            = 1'b0;
        pwa            = '0;
        pwd            = '0;
        owe            = 1'b0;
        owa            = '0;
        owd            = '0;

        age_p = req_reg.now - pq_reg.first;
        age_o = req_reg.now - oq_reg.last;
        stale = (age_p > cfg.stale);
        pv    = pvalid_reg[pridx_reg];
        pslot = hit_reg ? hit_idx_reg : free_idx_reg;
        oslot = ohit_reg ? ohit_idx_reg : (ofree_reg ? ofree_idx_reg : old_idx_reg);
        nh    = hit_reg ? abt_pkg::sat_inc16(pent_reg.hits) : 16'd1;
        nd    = hit_reg ? abt_pkg::sat_add32(pent_reg.danger, {16'd0, req_reg.danger})
                        : {16'd0, req_reg.danger};
        nc    = ohit_reg ? abt_pkg::sat_inc16(oent_reg.count) : 16'd1;
        nod   = ohit_reg ? abt_pkg::sat_add32(oent_reg.danger, pdng_reg) : pdng_reg;
        prod  = {5'd0, ban_reg} * {32'd0, cfg.growth};

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    req_next   = req;
                    pcnt_next  = '0;
                    hit_next   = 1'b0;
                    free_next  = 1'b0;
                    ban_next   = '0;
                    hits_next  = '0;
                    cnt_next   = '0;
                    odng_next  = '0;
                    state_next = ST_PSCAN;
                end
            end
            ST_PSCAN:
            begin
                if (pcnt_reg < PCW'(PENDING_DEPTH))
                begin
                    rv_next    = 1'b1;
                    pridx_next = pcnt_reg[PIW-1:0];
                    pcnt_next  = pcnt_reg + PCW'(1);
                end
                if (rv_reg)
                begin
                    // The purge comes first, so a stale entry never matches.
                    if (pv && stale)
                        pvalid_next[pridx_reg] = 1'b0;
                    if (pv && !stale && !hit_reg && pq_reg.addr == req_reg.addr)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pridx_reg;
                        pent_next    = pq_reg;
                    end
                    if ((!pv || stale) && !free_reg)
                    begin
                        free_next     = 1'b1;
                        free_idx_next = pridx_reg;
                    end
                end
                else if (pcnt_reg == PCW'(PENDING_DEPTH))
                    state_next = ST_PUPD;
            end
            ST_PUPD:
            begin
                if (req_reg.kind == abt_pkg::KIND_BLOCKED)
                begin
                    act_next   = abt_pkg::ACT_BLOCKED;
                    state_next = ST_OUT;
                end
                else if (req_reg.kind == abt_pkg::KIND_WHITE)
                begin
                    act_next   = abt_pkg::ACT_WHITE;
                    state_next = ST_OUT;
                end
                else if (!hit_reg && !free_reg)
                begin
                    act_next   = abt_pkg::ACT_FULL;
                    state_next = ST_OUT;
                end
                else
                begin
                    pwe        = 1'b1;
                    pwa        = pslot;
                    pwd.addr   = req_reg.addr;
                    pwd.hits   = nh;
                    pwd.danger = nd;
                    pwd.first  = hit_reg ? pent_reg.first : req_reg.now;
                    hits_next  = nh;
                    pdng_next  = nd;
                    if (nd < cfg.abuse_thr)
                    begin
                        pvalid_next[pslot] = 1'b1;
                        act_next           = abt_pkg::ACT_WATCH;
                        state_next         = ST_OUT;
                    end
                    else
                    begin
                        // A ban frees the pending entry.
                        pvalid_next[pslot] = 1'b0;
                        ocnt_next          = '0;
                        ohit_next          = 1'b0;
                        ofree_next         = 1'b0;
                        state_next         = ST_OSCAN;
                    end
                end
            end
            ST_OSCAN:
            begin
                if (ocnt_reg < OCW'(OFFENDER_DEPTH))
                begin
                    rv_next    = 1'b1;
                    oridx_next = ocnt_reg[OIW-1:0];
                    ocnt_next  = ocnt_reg + OCW'(1);
                end
                if (rv_reg)
                begin
                    if (ovalid_reg[oridx_reg] && !ohit_reg && oq_reg.addr == req_reg.addr)
                    begin
                        ohit_next     = 1'b1;
                        ohit_idx_next = oridx_reg;
                        oent_next     = oq_reg;
                    end
                    if (!ovalid_reg[oridx_reg] && !ofree_reg)
                    begin
                        ofree_next     = 1'b1;
                        ofree_idx_next = oridx_reg;
                    end
                    // Oldest entry; only used when every entry is valid.
                    if (oridx_reg == '0 || age_o > old_age_reg)
                    begin
                        old_age_next = age_o;
                        old_idx_next = oridx_reg;
                    end
                end
                else if (ocnt_reg == OCW'(OFFENDER_DEPTH))
                    state_next = ST_OUPD;
            end
            ST_OUPD:
            begin
                owe                = 1'b1;
                owa                = oslot;
                owd.addr           = req_reg.addr;
                owd.count          = nc;
                owd.danger         = nod;
                owd.last           = req_reg.now;
                ovalid_next[oslot] = 1'b1;
                cnt_next           = nc;
                odng_next          = nod;
                if (cfg.bl_en && nod >= cfg.bl_thr)
                begin
                    act_next   = abt_pkg::ACT_BLACK;
                    ban_next   = '0;
                    state_next = ST_OUT;
                end
                else
                begin
                    act_next   = abt_pkg::ACT_BANNED;
                    ban_next   = cfg.base_ban;
                    k_next     = 16'd1;
                    state_next = (cfg.growth > 5'd1) ? ST_GROW : ST_OUT;
                end
            end
            ST_GROW:
            begin
                if (k_reg < cnt_reg && ban_reg != 32'd0 && ban_reg != 32'hFFFF_FFFF)
                begin
                    ban_next = (|prod[36:32]) ? 32'hFFFF_FFFF : prod[31:0];
                    k_next   = k_reg + 16'd1;
                end
                else
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {5'd0, odng_reg, cnt_reg, hits_reg, ban_reg, act_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            pvalid_reg    <= '0;
            ovalid_reg    <= '0;
            pcnt_reg      <= '0;
            ocnt_reg      <= '0;
            rv_reg        <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            ohit_reg      <= 1'b0;
            ofree_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pvalid_reg    <= pvalid_next;
            ovalid_reg    <= ovalid_next;
            pcnt_reg      <= pcnt_next;
            ocnt_reg      <= ocnt_next;
            rv_reg        <= rv_next;
            hit_reg       <= hit_next;
            free_reg      <= free_next;
            ohit_reg      <= ohit_next;
            ofree_reg     <= ofree_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg       <= req_next;
        pridx_reg     <= pridx_next;
        oridx_reg     <= oridx_next;
        hit_idx_reg   <= hit_idx_next;
        pent_reg      <= pent_next;
        free_idx_reg  <= free_idx_next;
        ohit_idx_reg  <= ohit_idx_next;
        oent_reg      <= oent_next;
        ofree_idx_reg <= ofree_idx_next;
        old_idx_reg   <= old_idx_next;
        old_age_reg   <= old_age_next;
        act_reg       <= act_next;
        ban_reg       <= ban_next;
        hits_reg      <= hits_next;
        cnt_reg       <= cnt_next;
        odng_reg      <= odng_next;
        pdng_reg      <= pdng_next;
        k_reg         <= k_next;
        out_data_reg  <= out_data_next;
    end

endmodule
